// File: src/obb_sphere_contact_assert.svh
// Assertion macros used by the sphere-box contact top module.
`ifndef OBB_SPHERE_CONTACT_ASSERT_SVH
`define OBB_SPHERE_CONTACT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define OSC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define OSC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define OSC_ASSERT_IMP(label, clk, rst, ante, cons)
`define OSC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/osc_pkg.sv
// Package: formats, constants and shared types of the sphere-box contact block.
`default_nettype none
package osc_pkg;
   localparam int COORD_BITS = 20;
   localparam int FRAC_BITS  = 8;
   localparam int ROT_FRAC   = 14;
   localparam int ROT_BITS   = 16;
   localparam int HALF_BITS  = COORD_BITS - 1;
   localparam int TAG_BITS   = 16;
   localparam int CSR_BITS   = 60;
   localparam int CSR_IDX_BITS = 3;
   localparam int NORM_BITS  = 16;
   localparam int NORM_ONE   = 16384;
   // Widths of the datapath
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int ACC_BITS   = DIFF_BITS + ROT_BITS + 2;
   localparam int LOC_BITS   = ACC_BITS - ROT_FRAC;
   localparam int ERR_BITS   = LOC_BITS + 1;
   localparam int SQ_BITS    = 2 * HALF_BITS;
   localparam int D2_BITS    = SQ_BITS + 2;
   localparam int S_BITS     = D2_BITS / 2 + 1;
   localparam int U_BITS     = ROT_BITS + HALF_BITS + 3;
   localparam int Q_BITS     = 15;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS  = 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ROT_ROW0 = 3'd0,
      CSR_ROT_ROW1 = 3'd1,
      CSR_ROT_ROW2 = 3'd2,
      CSR_BOX_CENTER = 3'd3,
      CSR_HALF_EXTENT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] center_x;
      logic signed [COORD_BITS-1:0] center_y;
      logic signed [COORD_BITS-1:0] center_z;
      logic [HALF_BITS-1:0]         radius;
      logic [TAG_BITS-1:0]          sphere_tag;
   } req_word_type;

   typedef struct packed {
      logic                         hit;
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] point_z;
      logic signed [NORM_BITS-1:0]  normal_x;
      logic signed [NORM_BITS-1:0]  normal_y;
      logic signed [NORM_BITS-1:0]  normal_z;
      logic [HALF_BITS-1:0]         penetration;
      logic [TAG_BITS-1:0]          result_tag;
   } rsp_word_type;

   // Classified word handed from front to back
   typedef struct packed {
      logic                         hit;
      logic signed [COORD_BITS:0]   p0;
      logic signed [COORD_BITS:0]   p1;
      logic signed [COORD_BITS:0]   p2;
      logic signed [HALF_BITS+1:0]  e0;
      logic signed [HALF_BITS+1:0]  e1;
      logic signed [HALF_BITS+1:0]  e2;
      logic [D2_BITS-1:0]           dist2;
      logic [HALF_BITS-1:0]         radius;
      logic [TAG_BITS-1:0]          tag;
   } job_type;

   typedef struct packed {
      logic signed [ROT_BITS-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
      logic signed [COORD_BITS-1:0] b0, b1, b2;
      logic [HALF_BITS-1:0] h0, h1, h2;
   } box_type;

   // Round right shift by ROT_FRAC, halves toward plus infinity
   function automatic logic signed [LOC_BITS-1:0] rnd14(input logic signed [ACC_BITS-1:0] v);
      logic signed [ACC_BITS-1:0] x;
      x = v + ACC_BITS'(1 << (ROT_FRAC - 1));
      return LOC_BITS'(x >>> ROT_FRAC);
   endfunction
endpackage
`default_nettype wire

// File: src/osc_if.sv
// Valid/ready channel interface carrying one word.
`default_nettype none
interface osc_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

// File: src/obb_sphere_contact.sv
// Stages: front 4, queue 1, back 38; one word per cycle unless the result side stalls.
// Back latency is set by the 20-step square root and 15-step divide chains.
// A 4-entry queue lets the front run while the result side stalls.
// Reset (synchronous, active high) clears valid state and all box registers.
`default_nettype none
module obb_sphere_contact (
   input  wire logic clock,
   input  wire logic reset,
   osc_if.sink       req,
   osc_if.source     rsp,
   input  wire logic csr_we,
   input  wire logic [osc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [osc_pkg::CSR_BITS-1:0]     csr_wdata
);
   import osc_pkg::*;
   `include "obb_sphere_contact_assert.svh"

   logic [47:0] row_ff [3];
   logic [CSR_BITS-1:0] ctr_ff;
   logic [3*HALF_BITS-1:0] hx_ff;
   box_type box;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '{default: '0}; ctr_ff <= '0; hx_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROT_ROW0: row_ff[0] <= csr_wdata[47:0];
            CSR_ROT_ROW1: row_ff[1] <= csr_wdata[47:0];
            CSR_ROT_ROW2: row_ff[2] <= csr_wdata[47:0];
            CSR_BOX_CENTER: ctr_ff <= csr_wdata;
            CSR_HALF_EXTENT: hx_ff <= csr_wdata[3*HALF_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      box.r00 = row_ff[0][15:0]; box.r01 = row_ff[0][31:16]; box.r02 = row_ff[0][47:32];
      box.r10 = row_ff[1][15:0]; box.r11 = row_ff[1][31:16]; box.r12 = row_ff[1][47:32];
      box.r20 = row_ff[2][15:0]; box.r21 = row_ff[2][31:16]; box.r22 = row_ff[2][47:32];
      box.b0 = ctr_ff[COORD_BITS-1:0];
      box.b1 = ctr_ff[2*COORD_BITS-1:COORD_BITS];
      box.b2 = ctr_ff[3*COORD_BITS-1:2*COORD_BITS];
      box.h0 = hx_ff[HALF_BITS-1:0];
      box.h1 = hx_ff[2*HALF_BITS-1:HALF_BITS];
      box.h2 = hx_ff[3*HALF_BITS-1:2*HALF_BITS];
   end

   // Front pipeline: halts only when its last stage holds a word and the queue is full
   job_type fjob, qword;
   logic fvalid, qne, front_adv, back_adv, rsp_valid_in;
   logic [QPTR_BITS:0] qcnt;
   rsp_word_type bword;

   assign front_adv = qcnt == '0 || !(fvalid && qcnt == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign req.ready = front_adv;

   osc_front u_front (
      .clock(clock), .reset(reset), .box(box), .adv(front_adv),
      .in_valid(req.valid && front_adv), .in_word(req.word),
      .job_out(fjob), .job_valid(fvalid)
   );

   logic q_push, q_pop;
   assign q_push = fvalid && front_adv;
   assign back_adv = !rsp.valid || rsp.ready;
   assign q_pop = qne && back_adv;

   osc_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_word(fjob),
      .pop(q_pop), .pop_word(qword), .not_empty(qne), .count(qcnt)
   );

   // Back pipeline stalls as one with the output register
   logic bvalid;
   osc_back u_back (
      .clock(clock), .reset(reset), .box(box), .adv(back_adv),
      .in_valid(q_pop), .job(qword), .out_valid(bvalid), .out_word(bword)
   );

   assign rsp_valid_in = bvalid;
   assign rsp.valid = rsp_valid_in;
   assign rsp.word = bword;

   `OSC_ASSERT_IMP(a_no_overflow, clock, reset, q_push && !q_pop,
                   qcnt < (QPTR_BITS+1)'(QUEUE_DEPTH))
   `OSC_ASSERT_IMP(a_no_underflow, clock, reset, q_pop, qcnt != '0)
   `OSC_ASSERT_NXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
endmodule
`default_nettype wire

// File: src/osc_front.sv
// Front: box-space transform, clamp and hit classification, 4-stage pipeline.
`default_nettype none
module osc_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire osc_pkg::box_type box,
   input  wire logic            adv,
   input  wire logic            in_valid,
   input  wire osc_pkg::req_word_type in_word,
   output osc_pkg::job_type     job_out,
   output logic                 job_valid
);
   import osc_pkg::*;
   localparam int EB = HALF_BITS + 2;

   logic [3:0] v_ff, v_in;
   // stage 1: differences
   logic signed [DIFF_BITS-1:0] d_ff [3], d_in [3];
   logic [HALF_BITS-1:0] r1_ff, r2_ff, r3_ff;
   logic [TAG_BITS-1:0]  t1_ff, t2_ff, t3_ff;
   // stage 2: local coordinates
   logic signed [LOC_BITS-1:0] l_ff [3], l_in [3];
   // stage 3: clamp
   logic signed [COORD_BITS:0] p_ff [3], p_in [3];
   logic signed [EB-1:0] e_ff [3], e_in [3];
   logic                 far_ff, far_in;
   job_type              job_ff, job_in;
   logic signed [ROT_BITS-1:0] rc [3][3];
   logic [HALF_BITS-1:0] hh [3];

   always_comb begin
      rc[0][0] = box.r00; rc[0][1] = box.r01; rc[0][2] = box.r02;
      rc[1][0] = box.r10; rc[1][1] = box.r11; rc[1][2] = box.r12;
      rc[2][0] = box.r20; rc[2][1] = box.r21; rc[2][2] = box.r22;
      hh[0] = box.h0; hh[1] = box.h1; hh[2] = box.h2;
      v_in = {v_ff[2:0], in_valid};
      d_in[0] = DIFF_BITS'(in_word.center_x) - DIFF_BITS'(box.b0);
      d_in[1] = DIFF_BITS'(in_word.center_y) - DIFF_BITS'(box.b1);
      d_in[2] = DIFF_BITS'(in_word.center_z) - DIFF_BITS'(box.b2);
   end

   // Box-space projection, one multiply per term
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         l_in[j] = rnd14(ACC_BITS'(d_ff[0] * rc[0][j]) + ACC_BITS'(d_ff[1] * rc[1][j])
                   + ACC_BITS'(d_ff[2] * rc[2][j]));
      end
   end

   // Clamp to half extents and early reject
   always_comb begin
      logic signed [LOC_BITS-1:0] hs;
      logic signed [LOC_BITS-1:0] pc, ec;
      far_in = 1'b0;
      for (int j = 0; j < 3; j++) begin
         hs = LOC_BITS'(hh[j]);
         if (l_ff[j] > hs) pc = hs;
         else if (l_ff[j] < -hs) pc = -hs;
         else pc = l_ff[j];
         ec = pc - l_ff[j];
         p_in[j] = (COORD_BITS+1)'(pc);
         e_in[j] = EB'(ec);
         if ((ec < 0 ? -ec : ec) > LOC_BITS'(r2_ff)) far_in = 1'b1;
      end
   end

   // Squared distance and hit decision
   always_comb begin
      logic [SQ_BITS-1:0] sq [3];
      logic [D2_BITS-1:0] d2;
      for (int j = 0; j < 3; j++)
         sq[j] = SQ_BITS'(e_ff[j] * e_ff[j]);
      d2 = D2_BITS'(sq[0]) + D2_BITS'(sq[1]) + D2_BITS'(sq[2]);
      job_in.hit = !far_ff && (d2 <= D2_BITS'(r3_ff * r3_ff));
      job_in.p0 = p_ff[0]; job_in.p1 = p_ff[1]; job_in.p2 = p_ff[2];
      job_in.e0 = e_ff[0]; job_in.e1 = e_ff[1]; job_in.e2 = e_ff[2];
      job_in.dist2 = d2;
      job_in.radius = r3_ff;
      job_in.tag = t3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff <= d_in; r1_ff <= in_word.radius; t1_ff <= in_word.sphere_tag;
         l_ff <= l_in; r2_ff <= r1_ff; t2_ff <= t1_ff;
         p_ff <= p_in; e_ff <= e_in; far_ff <= far_in; r3_ff <= r2_ff; t3_ff <= t2_ff;
         job_ff <= job_in;
      end
   end

   assign job_out = job_ff;
   assign job_valid = v_ff[3];
endmodule
`default_nettype wire

// File: src/osc_queue.sv
// Small FIFO between front and back.
`default_nettype none
module osc_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire osc_pkg::job_type push_word,
   input  wire logic            pop,
   output osc_pkg::job_type     pop_word,
   output logic                 not_empty,
   output logic [osc_pkg::QPTR_BITS:0] count
);
   import osc_pkg::*;
   job_type mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wp_ff, rp_ff;
   logic [QPTR_BITS:0]   cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_word;
   end

   assign pop_word = mem_ff[rp_ff];
   assign not_empty = cnt_ff != '0;
   assign count = cnt_ff;
endmodule
`default_nettype wire

// File: src/osc_back.sv
// Back: world point, square root, normal division and output register.
`default_nettype none
module osc_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire osc_pkg::box_type box,
   input  wire logic            adv,
   input  wire logic            in_valid,
   input  wire osc_pkg::job_type job,
   output logic                 out_valid,
   output osc_pkg::rsp_word_type out_word
);
   import osc_pkg::*;
   localparam int NS = D2_BITS / 2;  // sqrt stages
   localparam int QS = Q_BITS;       // divide stages
   localparam int DEPTH = 1 + (NS + 1) + (QS + 1);
   localparam int UB = U_BITS;
   localparam int DV = UB + 2;

   logic signed [ROT_BITS-1:0] rc [3][3];
   logic signed [COORD_BITS-1:0] bb [3];
   logic [DEPTH-1:0] v_ff;

   // stage A: world point and rotated error
   job_type a_job_ff;
   logic signed [COORD_BITS-1:0] pt_ff [3], pt_in [3];
   logic signed [UB-1:0] u_ff [3], u_in [3];

   always_comb begin
      logic signed [ACC_BITS-1:0] acc;
      logic signed [LOC_BITS+1:0] w;
      logic signed [COORD_BITS:0] pj [3];
      logic signed [HALF_BITS+1:0] ej [3];
      rc[0][0] = box.r00; rc[0][1] = box.r01; rc[0][2] = box.r02;
      rc[1][0] = box.r10; rc[1][1] = box.r11; rc[1][2] = box.r12;
      rc[2][0] = box.r20; rc[2][1] = box.r21; rc[2][2] = box.r22;
      bb[0] = box.b0; bb[1] = box.b1; bb[2] = box.b2;
      pj[0] = job.p0; pj[1] = job.p1; pj[2] = job.p2;
      ej[0] = job.e0; ej[1] = job.e1; ej[2] = job.e2;
      for (int i = 0; i < 3; i++) begin
         acc = ACC_BITS'(rc[i][0] * pj[0]) + ACC_BITS'(rc[i][1] * pj[1])
             + ACC_BITS'(rc[i][2] * pj[2]);
         w = (LOC_BITS+2)'(rnd14(acc)) + (LOC_BITS+2)'(bb[i]);
         if (w > (LOC_BITS+2)'((1 << (COORD_BITS-1)) - 1))
            pt_in[i] = {1'b0, {(COORD_BITS-1){1'b1}}};
         else if (w < -(LOC_BITS+2)'(1 << (COORD_BITS-1)))
            pt_in[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
         else pt_in[i] = COORD_BITS'(w);
         u_in[i] = UB'(rc[i][0] * ej[0]) + UB'(rc[i][1] * ej[1]) + UB'(rc[i][2] * ej[2]);
      end
   end

   // Square root: one result bit per stage
   logic [D2_BITS-1:0] sx_ff [NS+1];
   logic [S_BITS-1:0]  sr_ff [NS+1];
   logic [D2_BITS-1:0] sv_ff [NS+1];
   job_type            sj_ff [NS+1];
   logic signed [COORD_BITS-1:0] sp_ff [NS+1][3];
   logic signed [UB-1:0] su_ff [NS+1][3];

   always_ff @(posedge clock) begin
      if (adv) begin
         a_job_ff <= job; pt_ff <= pt_in; u_ff <= u_in;
         sx_ff[0] <= '0; sr_ff[0] <= '0; sv_ff[0] <= a_job_ff.dist2;
         sj_ff[0] <= a_job_ff; sp_ff[0] <= pt_ff; su_ff[0] <= u_ff;
         for (int k = 0; k < NS; k++) begin : sq_stage
            logic [D2_BITS+1:0] rem;
            logic [D2_BITS+1:0] trial;
            rem = {sx_ff[k], sv_ff[k][D2_BITS-1 -: 2]};
            trial = (D2_BITS+2)'({sr_ff[k], 2'b01});
            if (rem >= trial) begin
               sx_ff[k+1] <= D2_BITS'(rem - trial);
               sr_ff[k+1] <= {sr_ff[k][S_BITS-2:0], 1'b1};
            end else begin
               sx_ff[k+1] <= D2_BITS'(rem);
               sr_ff[k+1] <= {sr_ff[k][S_BITS-2:0], 1'b0};
            end
            sv_ff[k+1] <= sv_ff[k] << 2;
            sj_ff[k+1] <= sj_ff[k]; sp_ff[k+1] <= sp_ff[k]; su_ff[k+1] <= su_ff[k];
         end
      end
   end

   // Round sqrt: remainder above floor root means round up
   logic [S_BITS-1:0] s_rnd;
   assign s_rnd = sr_ff[NS] + S_BITS'(S_BITS'(sx_ff[NS]) > sr_ff[NS]);

   // Divider: q = (2*mag + s) / (2*s), restoring, one quotient bit per stage
   logic [S_BITS:0]  dd_ff [QS+1];
   logic [2:0]       ng_ff [QS+1];
   job_type          dj_ff [QS+1];
   logic [S_BITS-1:0] ds_ff [QS+1];
   logic signed [COORD_BITS-1:0] dp_ff [QS+1][3];
   logic [3*QS-1:0]  q3_ff [QS+1];
   logic [3*DV-1:0]  n3_ff [QS+1];
   logic [3*DV-1:0]  r3_ff [QS+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         logic [UB-1:0] mag;
         logic [DV-1:0] num;
         for (int i = 0; i < 3; i++) begin
            mag = su_ff[NS][i] < 0 ? UB'(-su_ff[NS][i]) : UB'(su_ff[NS][i]);
            num = DV'({mag, 1'b0}) + DV'(s_rnd);
            n3_ff[0][i*DV +: DV] <= num;
            // remainder starts from the part above the QS quotient bits
            r3_ff[0][i*DV +: DV] <= num >> QS;
            ng_ff[0][i] <= su_ff[NS][i] < 0;
         end
         q3_ff[0] <= '0;
         dd_ff[0] <= {s_rnd, 1'b0};
         ds_ff[0] <= s_rnd;
         dj_ff[0] <= sj_ff[NS]; dp_ff[0] <= sp_ff[NS];
         for (int k = 0; k < QS; k++) begin : div_stage
            logic [DV:0] rr;
            logic [DV-1:0] nn;
            for (int i = 0; i < 3; i++) begin
               nn = n3_ff[k][i*DV +: DV];
               rr = {r3_ff[k][i*DV +: DV], nn[QS-1 - k]};
               if (rr >= (DV+1)'(dd_ff[k])) begin
                  r3_ff[k+1][i*DV +: DV] <= DV'(rr - (DV+1)'(dd_ff[k]));
                  q3_ff[k+1][i*QS + QS-1-k] <= 1'b1;
               end else begin
                  r3_ff[k+1][i*DV +: DV] <= DV'(rr);
                  q3_ff[k+1][i*QS + QS-1-k] <= 1'b0;
               end
               for (int b = 0; b < QS; b++)
                  if (b != QS-1-k) q3_ff[k+1][i*QS + b] <= q3_ff[k][i*QS + b];
            end
            n3_ff[k+1] <= n3_ff[k]; ng_ff[k+1] <= ng_ff[k]; dd_ff[k+1] <= dd_ff[k];
            ds_ff[k+1] <= ds_ff[k]; dj_ff[k+1] <= dj_ff[k]; dp_ff[k+1] <= dp_ff[k];
         end
      end
   end

   // Valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[DEPTH-2:0], in_valid};
      end
   end

   // Final assembly. A quotient above one saturates to one; so does one of 2^QS
   // or more, which shows up as a numerator high part at or above the divisor.
   always_comb begin
      job_type   fj;
      logic [S_BITS-1:0] s;
      logic [QS-1:0] q;
      logic [DV-1:0] hi;
      logic signed [NORM_BITS-1:0] n [3];
      logic big;
      fj = dj_ff[QS];
      s = ds_ff[QS];
      for (int i = 0; i < 3; i++) begin
         q = q3_ff[QS][i*QS +: QS];
         hi = n3_ff[QS][i*DV +: DV] >> QS;
         big = hi >= DV'(dd_ff[QS]) || q > QS'(NORM_ONE);
         if (big) q = QS'(NORM_ONE);
         n[i] = ng_ff[QS][i] ? -NORM_BITS'(q) : NORM_BITS'(q);
         if (fj.dist2 == '0 || s == '0) n[i] = '0;
      end
      out_word.hit = fj.hit;
      out_word.result_tag = fj.tag;
      if (fj.hit) begin
         out_word.point_x = dp_ff[QS][0];
         out_word.point_y = dp_ff[QS][1];
         out_word.point_z = dp_ff[QS][2];
         out_word.normal_x = n[0]; out_word.normal_y = n[1]; out_word.normal_z = n[2];
         out_word.penetration = (S_BITS'(fj.radius) > s) ?
                                HALF_BITS'(S_BITS'(fj.radius) - s) : '0;
      end else begin
         out_word.point_x = '0; out_word.point_y = '0; out_word.point_z = '0;
         out_word.normal_x = '0; out_word.normal_y = '0; out_word.normal_z = '0;
         out_word.penetration = '0;
      end
   end

   assign out_valid = v_ff[DEPTH-1];
endmodule
`default_nettype wire

// File: sim/tb.sv
// Self-checking bench for the sphere-box contact block: directed and random words.
`timescale 1ns / 100ps
module tb;
   import osc_pkg::*;

   localparam int HALF_PERIOD = 2;
   localparam int WATCH_LIMIT = 20000;
   localparam int LONG_HOLD = 400;
   localparam int RAND_PHASES = 10;
   localparam int WORDS_PER_PHASE = 133;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED_IDX = 3'd7;
   localparam longint CMIN = -(longint'(1) << (COORD_BITS - 1));
   localparam longint CMAX = (longint'(1) << (COORD_BITS - 1)) - 1;

   typedef struct {
      bit           typed;
      rsp_word_type fixed;
   } plan_type;

   typedef struct {
      int           box_set;
      req_word_type w;
      bit           typed;
      rsp_word_type fixed;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_BITS-1:0] csr_wdata = '0;

   osc_if #(.word_type(req_word_type)) req_ch ();
   osc_if #(.word_type(rsp_word_type)) rsp_ch ();

   obb_sphere_contact DUT (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // box as the hardware should hold it
   longint rot_e [3][3];
   longint box_c [3];
   longint half_e [3];
   // scratch box built before a load
   longint nrot [3][3];
   longint ncen [3];
   longint nhalf [3];

   plan_type     planned [$];
   rsp_word_type contacts_due [$];
   row_type      rows [$];
   int fail_count = 0;
   int idle_pct = 36;
   int stall_asked = 0;
   int stall_done = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   always #(HALF_PERIOD) clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.word = '0;
      for (int i = 0; i < 3; i++) begin
         box_c[i] = 0;
         half_e[i] = 0;
         for (int j = 0; j < 3; j++) rot_e[i][j] = 0;
      end
   end

   function automatic longint clampl(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint round_sqrt(longint v);
      longint r;
      r = 0;
      for (int b = 31; b >= 0; b--)
         if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v) r += longint'(1) << b;
      if (v - r * r > r) r++;
      return r;
   endfunction

   // closest point, normal and depth of one sphere against the held box
   function automatic rsp_word_type predict_contact(req_word_type w);
      rsp_word_type o;
      longint d [3];
      longint p [3];
      longint e [3];
      longint acc, loc, ae, r, dist2, s, mag, q;
      o = '0;
      o.result_tag = w.sphere_tag;
      r = longint'(w.radius);
      d[0] = longint'($signed(w.center_x)) - box_c[0];
      d[1] = longint'($signed(w.center_y)) - box_c[1];
      d[2] = longint'($signed(w.center_z)) - box_c[2];
      dist2 = 0;
      for (int j = 0; j < 3; j++) begin
         acc = 0;
         for (int i = 0; i < 3; i++) acc += d[i] * rot_e[i][j];
         loc = (acc + 8192) >>> ROT_FRAC;
         p[j] = clampl(loc, -half_e[j], half_e[j]);
         e[j] = p[j] - loc;
         ae = e[j] < 0 ? -e[j] : e[j];
         if (ae > r) return o;
         dist2 += ae * ae;
      end
      if (dist2 > r * r) return o;
      o.hit = 1'b1;
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) acc += rot_e[i][j] * p[j];
         acc = clampl(((acc + 8192) >>> ROT_FRAC) + box_c[i], CMIN, CMAX);
         if (i == 0) o.point_x = acc[COORD_BITS-1:0];
         else if (i == 1) o.point_y = acc[COORD_BITS-1:0];
         else o.point_z = acc[COORD_BITS-1:0];
      end
      s = round_sqrt(dist2);
      o.penetration = (s > r) ? '0 : HALF_BITS'(r - s);
      if (dist2 != 0 && s != 0)
         for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += rot_e[i][j] * e[j];
            mag = acc < 0 ? -acc : acc;
            q = (2 * mag + s) / (2 * s);
            if (q > NORM_ONE) q = NORM_ONE;
            if (acc < 0) q = -q;
            if (i == 0) o.normal_x = q[NORM_BITS-1:0];
            else if (i == 1) o.normal_y = q[NORM_BITS-1:0];
            else o.normal_z = q[NORM_BITS-1:0];
         end
      return o;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         fail_count++;
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // input acceptance queues the expectation; result acceptance checks it
   always @(posedge clock) begin
      plan_type pl;
      rsp_word_type want, got;
      if (!reset && req_ch.valid && req_ch.ready) begin
         pl = planned.pop_front();
         contacts_due = {contacts_due, (pl.typed ? pl.fixed : predict_contact(req_ch.word))};
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.word;
         if (contacts_due.size() == 0) begin
            fail_count++;
            $display("%0t unexpected word: expected none, actual tag %0d", $time,
                     got.result_tag);
         end else begin
            want = contacts_due.pop_front();
            check_field("hit", want.hit, got.hit);
            check_field("point_x", $signed(want.point_x), $signed(got.point_x));
            check_field("point_y", $signed(want.point_y), $signed(got.point_y));
            check_field("point_z", $signed(want.point_z), $signed(got.point_z));
            check_field("normal_x", $signed(want.normal_x), $signed(got.normal_x));
            check_field("normal_y", $signed(want.normal_y), $signed(got.normal_y));
            check_field("normal_z", $signed(want.normal_z), $signed(got.normal_z));
            check_field("penetration", want.penetration, got.penetration);
            check_field("result_tag", want.result_tag, got.result_tag);
         end
      end
   end

   // result side: random back-pressure plus requested long holds
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else if (stall_asked != stall_done) begin
         stall_done = stall_asked;
         stall_left = LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCH_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else quiet_cycles <= quiet_cycles + 1;
   end

   // one register write, then csr_we low before the task returns
   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_BITS-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ROT_ROW0, CSR_ROT_ROW1, CSR_ROT_ROW2:
            for (int j = 0; j < 3; j++) rot_e[idx][j] = $signed(data[16*j +: 16]);
         CSR_BOX_CENTER:
            for (int j = 0; j < 3; j++) box_c[j] = $signed(data[20*j +: 20]);
         CSR_HALF_EXTENT:
            for (int j = 0; j < 3; j++) half_e[j] = data[19*j +: 19];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // write the scratch box into the block
   task automatic load_box();
      logic [CSR_BITS-1:0] v;
      for (int i = 0; i < 3; i++) begin
         v = '0;
         for (int j = 0; j < 3; j++) v[16*j +: 16] = nrot[i][j][15:0];
         write_csr(csr_index_type'(i), v);
      end
      v = '0;
      for (int j = 0; j < 3; j++) v[20*j +: 20] = ncen[j][19:0];
      write_csr(CSR_BOX_CENTER, v);
      v = '0;
      for (int j = 0; j < 3; j++) v[19*j +: 19] = nhalf[j][18:0];
      write_csr(CSR_HALF_EXTENT, v);
   endtask

   task automatic axis_rotation(int ax, longint c, longint s);
      int u, v;
      u = (ax + 1) % 3;
      v = (ax + 2) % 3;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) nrot[i][j] = 0;
      nrot[ax][ax] = NORM_ONE;
      nrot[u][u] = c;
      nrot[u][v] = -s;
      nrot[v][u] = s;
      nrot[v][v] = c;
   endtask

   task automatic directed_box(int k);
      case (k)
         1: begin
            axis_rotation(0, NORM_ONE, 0);
            ncen = '{2560, -1280, 768};
            nhalf = '{1024, 512, 256};
         end
         2: begin
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++) nrot[i][j] = 32767;
            ncen = '{CMAX, CMAX, CMAX};
            nhalf = '{CMAX, CMAX, CMAX};
         end
         default: begin
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++) nrot[i][j] = -32768;
            ncen = '{CMIN, CMIN, CMIN};
            nhalf = '{0, 0, 0};
         end
      endcase
      load_box();
   endtask

   task automatic random_box(int ph);
      longint cs [4] = '{14189, 11585, 8192, 0};
      longint sn [4] = '{8192, 11585, 14189, 16384};
      int a;
      if (ph % 4 == 3) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) nrot[i][j] = $signed(16'($urandom));
      end else begin
         a = $urandom_range(3);
         axis_rotation($urandom_range(2), cs[a], ($urandom_range(1) ? sn[a] : -sn[a]));
      end
      for (int j = 0; j < 3; j++) begin
         ncen[j] = (ph == 7) ? $signed(20'($urandom)) : longint'($urandom_range(131072)) - 65536;
         nhalf[j] = (ph == 8) ? CMAX : longint'($urandom_range(4096));
      end
      load_box();
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (planned.size() != 0 || contacts_due.size() != 0) @(posedge clock);
   endtask

   // idle cycles come one at a time, each with chance idle_pct
   task automatic offer_word(req_word_type w, bit typed, rsp_word_type fx);
      plan_type pl;
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      pl.typed = typed;
      pl.fixed = fx;
      planned = {planned, pl};
      req_ch.valid <= 1'b1;
      req_ch.word <= w;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic req_word_type sphere_word(int noise);
      req_word_type w;
      longint c [3];
      longint reach;
      w.sphere_tag = 16'($urandom);
      if (noise != 0) begin
         w.center_x = 20'($urandom);
         w.center_y = 20'($urandom);
         w.center_z = 20'($urandom);
         w.radius = 19'($urandom);
         return w;
      end
      reach = half_e[0] + half_e[1] + half_e[2] + 2048;
      if (reach > 200000) reach = 200000;
      for (int j = 0; j < 3; j++)
         c[j] = clampl(box_c[j] + longint'($urandom_range(2 * reach)) - reach, CMIN, CMAX);
      w.center_x = c[0][19:0];
      w.center_y = c[1][19:0];
      w.center_z = c[2][19:0];
      w.radius = ($urandom_range(9) == 0) ? 19'($urandom) : 19'($urandom_range(3072));
      return w;
   endfunction

   function automatic row_type mk(int k, longint cx, longint cy, longint cz, longint r,
                                  int typed, int hit);
      row_type rw;
      rw.box_set = k;
      rw.w.center_x = cx[19:0];
      rw.w.center_y = cy[19:0];
      rw.w.center_z = cz[19:0];
      rw.w.radius = r[18:0];
      rw.w.sphere_tag = 16'($urandom);
      rw.typed = (typed != 0);
      rw.fixed = '0;
      rw.fixed.result_tag = rw.w.sphere_tag;
      rw.fixed.hit = (hit != 0);
      if (hit != 0) rw.fixed.penetration = r[18:0];
      return rw;
   endfunction

   initial begin
      req_word_type w;
      int cur_set;
      // box zeroed by reset: everything touches, point at origin, depth is radius
      rows = {rows, mk(0, 0, 0, 0, 0, 1, 1)};
      rows = {rows, mk(0, CMAX, CMAX, CMAX, CMAX, 1, 1)};
      rows = {rows, mk(0, CMIN, CMIN, CMIN, 12345, 1, 1)};
      rows = {rows, mk(0, CMIN, CMAX, 0, 0, 1, 1)};
      // axis-aligned box at an offset: inside, far miss, touch, early reject, corners, huge radius
      rows = {rows, mk(1, 2560, -1280, 768, 0, 0, 0)};
      rows = {rows, mk(1, CMAX, CMAX, CMAX, 100, 1, 0)};
      rows = {rows, mk(1, 2560 + 1024 + 300, -1280, 768, 300, 0, 0)};
      rows = {rows, mk(1, 2560 + 1024 + 301, -1280, 768, 300, 1, 0)};
      rows = {rows, mk(1, 2560 + 1500, -1280 + 900, 768 + 400, 256, 1, 0)};
      rows = {rows, mk(1, 2560 + 1200, -1280 + 700, 768 + 300, 500, 0, 0)};
      rows = {rows, mk(1, 2560 - 1100, -1280 - 520, 768 - 260, 120, 0, 0)};
      rows = {rows, mk(1, 2560 + 500, -1280 - 100, 768 + 100, CMAX, 0, 0)};
      // saturating boxes, non-orthonormal rotation
      rows = {rows, mk(2, CMIN, CMIN, CMIN, CMAX, 0, 0)};
      rows = {rows, mk(2, CMAX, CMAX, CMAX, 0, 0, 0)};
      rows = {rows, mk(2, CMIN, CMAX, 0, CMAX, 0, 0)};
      rows = {rows, mk(3, CMAX, CMAX, CMAX, CMAX, 0, 0)};
      rows = {rows, mk(3, CMIN, CMIN, CMIN, 0, 0, 0)};
      rows = {rows, mk(3, 0, 0, 0, 77, 0, 0)};
      rows = {rows, mk(3, CMIN + 5, CMIN, CMIN + 3, 4, 0, 0)};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      cur_set = 0;
      foreach (rows[n]) begin
         if (rows[n].box_set != cur_set) begin
            drain();
            cur_set = rows[n].box_set;
            directed_box(cur_set);
            if (cur_set == 1) write_csr(CSR_UNUSED_IDX, '1);
         end
         offer_word(rows[n].w, rows[n].typed, rows[n].fixed);
      end

      // random phases: mostly spheres around the box, some raw noise
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         drain();
         random_box(ph);
         idle_pct = (ph == 3) ? 0 : 36;
         if (ph == 5 || ph == 9) stall_asked++;
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            w = sphere_word($urandom_range(4) == 0);
            offer_word(w, 1'b0, '0);
         end
      end
      idle_pct = 36;
      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
